// ----- src/gsa_pkg.sv -----
// Shared types, constants and codes for the generational slot allocator.
// No dependencies; every other source file refers to it by scoped names.
`default_nettype none

package gsa_pkg;

  localparam int MAX_SLOTS  = 256;
  localparam int IDX_W      = 8;
  localparam int CELL_SLOTS = 8;
  localparam int LOC_W      = $clog2(CELL_SLOTS);
  localparam int NCELLS     = MAX_SLOTS / CELL_SLOTS;
  localparam int CELL_ID_W  = IDX_W - LOC_W;
  localparam int CNT_W      = $clog2(NCELLS);
  localparam int SLOT_CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CFG_W      = 9;
  localparam int GEN_W      = 32;
  localparam int FLAGS_W    = 32;
  localparam int TAG_W      = 32;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int IN_FIELD_W = IDX_W + GEN_W + FLAGS_W + TAG_W;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = STATUS_W + 1 + IDX_W + GEN_W + TAG_W;
  localparam int OUT_DATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [GEN_W-1:0] GEN_MAX   = {GEN_W{1'b1}};
  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);
  localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(MAX_SLOTS);

  localparam logic [OP_W-1:0] OP_DESTROY = 2'd0;
  localparam logic [OP_W-1:0] OP_SPAWN   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_ALIVE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PICK,
    ST_LOOKUP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             wr;
    logic [IDX_W-1:0] index;
    logic             live;
    logic             create;
    logic             retire;
  } slot_cmd_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } cand_t;

endpackage

`default_nettype wire

// ----- src/gsa_cell.sv -----
// One cell of the slot chain: live, created and retired bits for a group of slots.
// Finds its lowest reusable slot and passes the best candidate to its lower neighbor.
// Depends on gsa_pkg.
`default_nettype none

module gsa_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [gsa_pkg::CELL_ID_W-1:0]  cell_id,
  input  gsa_pkg::slot_cmd_t             cmd,
  input  gsa_pkg::cand_t                 cand_in,
  output gsa_pkg::cand_t                 cand_out,
  output logic [gsa_pkg::CELL_SLOTS-1:0] live
);

  logic [gsa_pkg::CELL_SLOTS-1:0] created;
  logic [gsa_pkg::CELL_SLOTS-1:0] retired;
  logic [gsa_pkg::CELL_SLOTS-1:0] avail;
  logic                           loc_found;
  logic [gsa_pkg::LOC_W-1:0]      loc_idx;
  logic [gsa_pkg::LOC_W-1:0]      cmd_loc;
  logic                           cmd_hit;

  assign avail   = created & ~live & ~retired;
  assign cmd_loc = cmd.index[gsa_pkg::LOC_W-1:0];
  assign cmd_hit = cmd.wr && (cmd.index[gsa_pkg::IDX_W-1:gsa_pkg::LOC_W] == cell_id);

  always_comb begin
    loc_found = 1'b0;
    loc_idx   = '0;
    for (int j = gsa_pkg::CELL_SLOTS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        loc_found = 1'b1;
        loc_idx   = gsa_pkg::LOC_W'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= '0;
      created <= '0;
      retired <= '0;
    end else if (cmd_hit) begin
      live[cmd_loc] <= cmd.live;
      if (cmd.create) begin
        created[cmd_loc] <= 1'b1;
      end
      if (cmd.retire) begin
        retired[cmd_loc] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_out <= '0;
    end else if (loc_found) begin
      cand_out.found <= 1'b1;
      cand_out.index <= {cell_id, loc_idx};
    end else begin
      cand_out <= cand_in;
    end
  end

endmodule

`default_nettype wire

// ----- src/gsa_slot_chain.sv -----
// Row of slot cells; the lowest reusable slot ripples down to cell 0.
// Depends on gsa_pkg and gsa_cell.
`default_nettype none

module gsa_slot_chain (
  input  logic                          clk,
  input  logic                          rst,
  input  gsa_pkg::slot_cmd_t            cmd,
  output gsa_pkg::cand_t                cand,
  output logic [gsa_pkg::MAX_SLOTS-1:0] live_all
);

  gsa_pkg::cand_t link [gsa_pkg::NCELLS+1];

  assign link[gsa_pkg::NCELLS] = '0;
  assign cand = link[0];

  for (genvar k = 0; k < gsa_pkg::NCELLS; k++) begin : g_cell
    gsa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cell_id  (gsa_pkg::CELL_ID_W'(k)),
      .cmd      (cmd),
      .cand_in  (link[k+1]),
      .cand_out (link[k]),
      .live     (live_all[k*gsa_pkg::CELL_SLOTS +: gsa_pkg::CELL_SLOTS])
    );
  end

endmodule

`default_nettype wire

// ----- src/generational_slot_allocator_core.sv -----
// Top level of the generational slot allocator: control, generation and flags memories.
// Depends on gsa_pkg and gsa_slot_chain.
//
// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tuser opcode, s_tdata request fields
// m       | out | m_tvalid/m_tready  | m_tdata result fields
// cfg     | in  | cfg_wr_en          | cfg_wr_data max_entities
//
// Destroy and query step through accept, generation memory read and finish, in that order.
// Spawn searches and picks before the read: the candidate must ripple down the cell chain.
// One request is in flight; the finished result holds in the output register.
// Synchronous reset clears all slot bits at once; no clearing pass.
// A stalled output holds the request in its finish step.
`default_nettype none

module generational_slot_allocator_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // entity_index, entity_generation, entity_flags, request_tag
  input  logic [gsa_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode
  input  logic [gsa_pkg::OP_W-1:0]        s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status, handle_alive, new_index, new_generation, echoed_tag, zero fill
  output logic [gsa_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_wr_en,
  input  logic [gsa_pkg::CFG_W-1:0]       cfg_wr_data
);

  gsa_pkg::state_t state, state_next;

  logic [gsa_pkg::OP_W-1:0]       op_q;
  logic [gsa_pkg::GEN_W-1:0]      gen_q;
  logic [gsa_pkg::FLAGS_W-1:0]    flags_q;
  logic [gsa_pkg::TAG_W-1:0]      tag_q;
  logic [gsa_pkg::IDX_W-1:0]      slot_sel;
  logic [gsa_pkg::CNT_W-1:0]      cnt;
  logic                           found_q;
  logic                           append_q;
  logic [gsa_pkg::SLOT_CNT_W-1:0] slots_created;
  logic [gsa_pkg::CFG_W-1:0]      max_entities;
  logic [gsa_pkg::CFG_W-1:0]      limit;

  logic [gsa_pkg::GEN_W-1:0]   gen_mem [gsa_pkg::MAX_SLOTS];
  logic [gsa_pkg::FLAGS_W-1:0] pay_mem [gsa_pkg::MAX_SLOTS];
  logic [gsa_pkg::GEN_W-1:0]   gen_rd;

  gsa_pkg::slot_cmd_t            cmd;
  gsa_pkg::cand_t                cand;
  logic [gsa_pkg::MAX_SLOTS-1:0] live_all;

  logic                           in_xfer;
  logic                           out_free;
  logic                           finish_go;
  logic                           hit;
  logic [gsa_pkg::GEN_W-1:0]      gen_inc;
  logic                           gen_we;
  logic [gsa_pkg::GEN_W-1:0]      gen_wdata;
  logic                           pay_we;
  logic                           created_inc;
  logic [gsa_pkg::STATUS_W-1:0]   res_status;
  logic                           res_alive;
  logic [gsa_pkg::IDX_W-1:0]      res_index;
  logic [gsa_pkg::GEN_W-1:0]      res_gen;
  logic [gsa_pkg::TAG_W-1:0]      res_tag;

  gsa_slot_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cand     (cand),
    .live_all (live_all)
  );

  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign limit    = (max_entities > gsa_pkg::CFG_W'(gsa_pkg::MAX_SLOTS)) ?
                    gsa_pkg::CFG_W'(gsa_pkg::MAX_SLOTS) : max_entities;
  assign hit      = live_all[slot_sel] && (gen_rd == gen_q);
  assign gen_inc  = (gen_rd == gsa_pkg::GEN_MAX) ? gen_rd : gen_rd + gsa_pkg::GEN_W'(1);

  always_comb begin
    state_next = state;
    unique case (state)
      gsa_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (s_tuser == gsa_pkg::OP_SPAWN) ? gsa_pkg::ST_SEARCH :
                                                        gsa_pkg::ST_LOOKUP;
        end
      end
      gsa_pkg::ST_SEARCH: begin
        if (cnt == gsa_pkg::CNT_W'(gsa_pkg::NCELLS - 1)) begin
          state_next = gsa_pkg::ST_PICK;
        end
      end
      gsa_pkg::ST_PICK:   state_next = gsa_pkg::ST_LOOKUP;
      gsa_pkg::ST_LOOKUP: state_next = gsa_pkg::ST_FINISH;
      gsa_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = gsa_pkg::ST_IDLE;
        end
      end
      default: state_next = gsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = (state == gsa_pkg::ST_IDLE);
    finish_go   = (state == gsa_pkg::ST_FINISH) && out_free;
    cmd         = '0;
    cmd.index   = slot_sel;
    gen_we      = 1'b0;
    gen_wdata   = gen_inc;
    pay_we      = 1'b0;
    created_inc = 1'b0;
    res_status  = gsa_pkg::STAT_DONE;
    res_alive   = 1'b0;
    res_index   = '0;
    res_gen     = '0;
    res_tag     = '0;
    case (op_q)
      gsa_pkg::OP_DESTROY: begin
        if (hit) begin
          cmd.wr     = finish_go;
          cmd.live   = 1'b0;
          cmd.retire = (gen_inc == gsa_pkg::GEN_MAX);
          gen_we     = finish_go && (gen_rd != gsa_pkg::GEN_MAX);
        end else begin
          res_status = gsa_pkg::STAT_NOT_ALIVE;
        end
      end
      gsa_pkg::OP_SPAWN: begin
        res_tag = tag_q;
        if (found_q || append_q) begin
          cmd.wr      = finish_go;
          cmd.live    = 1'b1;
          cmd.create  = append_q;
          pay_we      = finish_go;
          gen_we      = finish_go && append_q;
          gen_wdata   = gsa_pkg::GEN_FIRST;
          created_inc = finish_go && append_q;
          res_index   = slot_sel;
          res_gen     = append_q ? gsa_pkg::GEN_FIRST : gen_rd;
        end else begin
          res_status = gsa_pkg::STAT_FULL;
        end
      end
      gsa_pkg::OP_QUERY: begin
        res_alive = hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entities <= gsa_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      max_entities <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_created <= '0;
      found_q       <= 1'b0;
      append_q      <= 1'b0;
      cnt           <= '0;
    end else begin
      if (created_inc) begin
        slots_created <= slots_created + gsa_pkg::SLOT_CNT_W'(1);
      end
      if (state == gsa_pkg::ST_IDLE) begin
        cnt      <= '0;
        found_q  <= 1'b0;
        append_q <= 1'b0;
      end else if (state == gsa_pkg::ST_SEARCH) begin
        cnt <= cnt + gsa_pkg::CNT_W'(1);
      end else if (state == gsa_pkg::ST_PICK) begin
        found_q  <= cand.found;
        append_q <= !cand.found &&
                    (gsa_pkg::CFG_W'(slots_created) < limit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_q     <= s_tuser;
      slot_sel <= s_tdata[gsa_pkg::IDX_W-1:0];
      gen_q    <= s_tdata[gsa_pkg::IDX_W +: gsa_pkg::GEN_W];
      flags_q  <= s_tdata[gsa_pkg::IDX_W + gsa_pkg::GEN_W +: gsa_pkg::FLAGS_W];
      tag_q    <= s_tdata[gsa_pkg::IDX_W + gsa_pkg::GEN_W + gsa_pkg::FLAGS_W +:
                          gsa_pkg::TAG_W];
    end else if (state == gsa_pkg::ST_PICK) begin
      slot_sel <= cand.found ? cand.index : slots_created[gsa_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[slot_sel] <= gen_wdata;
    end
    gen_rd <= gen_mem[slot_sel];
  end

  always_ff @(posedge clk) begin
    if (pay_we) begin
      pay_mem[slot_sel] <= flags_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      m_tdata <= gsa_pkg::OUT_DATA_W'({res_tag, res_gen, res_index, res_alive, res_status});
    end
  end

`ifndef SYNTHESIS
  a_pick_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(found_q && append_q))
    else $error("reuse and append chosen together");

  a_created_bound: assert property (@(posedge clk) disable iff (rst)
    slots_created <= gsa_pkg::SLOT_CNT_W'(gsa_pkg::MAX_SLOTS))
    else $error("slot count beyond storage");

  a_append_index: assert property (@(posedge clk) disable iff (rst)
    (state == gsa_pkg::ST_FINISH && append_q) |->
      (slot_sel == slots_created[gsa_pkg::IDX_W-1:0] &&
       slots_created < gsa_pkg::SLOT_CNT_W'(gsa_pkg::MAX_SLOTS)))
    else $error("append at wrong slot");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    finish_go |=> (state == gsa_pkg::ST_IDLE && m_tvalid))
    else $error("finish did not return to idle with a result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(finish_go))
    else $error("result without finish");
`endif

endmodule

`default_nettype wire
